@@ src/x86s_pkg.sv @@
// ----------------------------------------------------------------------------
// x86s_pkg
// types, opcode patterns and flag positions shared by the execute block
// ----------------------------------------------------------------------------
package x86s_pkg;

   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 16;
   localparam int REG_IDX_W  = 3;
   localparam int FLAG_W     = 6;

   // flag positions in the packed flag word
   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 1;
   localparam int FLAG_AF = 2;
   localparam int FLAG_ZF = 3;
   localparam int FLAG_SF = 4;
   localparam int FLAG_OF = 5;

   // opcode patterns, ? bits are don't care
   localparam logic [7:0] OP_INT     = 8'hCD;
   localparam logic [7:0] OP_MOV_IMM = 8'b1011_????;
   localparam logic [7:0] OP_XCHG    = 8'b1000_011?;
   localparam logic [7:0] OP_CMP_ACC = 8'b0011_110?;
   localparam logic [7:0] OP_JAE     = 8'h73;
   localparam logic [7:0] OP_XOR     = 8'b0011_00??;

   localparam logic [1:0] MOD_REG = 2'b11;

   // instruction lengths in bytes
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef enum logic [1:0] {
      ST_DONE        = 2'd0,
      ST_INT         = 2'd1,
      ST_UNKNOWN     = 2'd2,
      ST_UNSUPPORTED = 2'd3
   } status_type;

   // register file write request: one word port, two byte ports
   typedef struct packed {
      logic                 word_en;
      logic [REG_IDX_W-1:0] word_idx;
      logic [REG_W-1:0]     word_data;
      logic                 byte_a_en;
      logic [REG_IDX_W-1:0] byte_a_code;
      logic [7:0]           byte_a_data;
      logic                 byte_b_en;
      logic [REG_IDX_W-1:0] byte_b_code;
      logic [7:0]           byte_b_data;
   } rf_wr_type;

   // per-instruction outcome from the execute logic
   typedef struct packed {
      status_type         status;
      logic [15:0]        next_ip;
      logic               flags_we;
      logic [FLAG_W-1:0]  flags;
      logic [7:0]         int_vector;
   } exec_res_type;

endpackage

@@ src/x86s_req_if.sv @@
// ----------------------------------------------------------------------------
// x86s_req_if
// request channel: one whole instruction per request
// ----------------------------------------------------------------------------
interface x86s_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] second_byte;
   logic [7:0] third_byte;

   modport source (output valid, opcode, second_byte, third_byte, input ready);
   modport sink   (input valid, opcode, second_byte, third_byte, output ready);
endinterface

@@ src/x86s_rsp_if.sv @@
// ----------------------------------------------------------------------------
// x86s_rsp_if
// response channel: status, next ip, flags and interrupt vector
// ----------------------------------------------------------------------------
interface x86s_rsp_if import x86s_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [15:0]       next_ip;
   logic [FLAG_W-1:0] flag_bits;
   logic [7:0]        int_vector;

   modport source (output valid, status, next_ip, flag_bits, int_vector, input ready);
   modport sink   (input valid, status, next_ip, flag_bits, int_vector, output ready);
endinterface

@@ src/x86s_csr_if.sv @@
// ----------------------------------------------------------------------------
// x86s_csr_if
// configuration write channel for the start ip register
// ----------------------------------------------------------------------------
interface x86s_csr_if ();
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ src/x86s_regfile.sv @@
// ----------------------------------------------------------------------------
// x86s_regfile
// eight 16-bit general registers with 8086 byte-register write mapping
// ----------------------------------------------------------------------------
module x86s_regfile import x86s_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  rf_wr_type            wr,
   input  logic [REG_IDX_W-1:0] rd_a_idx,
   input  logic [REG_IDX_W-1:0] rd_b_idx,
   output logic [REG_W-1:0]     rd_a_data,
   output logic [REG_W-1:0]     rd_b_data,
   output logic [REG_W-1:0]     ax_data
);

   logic [REG_W-1:0] regs_ff [NUM_REGS];
   logic [REG_W-1:0] regs_in [NUM_REGS];

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (wr_en) begin
            if (wr.word_en && wr.word_idx == REG_IDX_W'(i)) begin
               regs_in[i] = wr.word_data;
            end
            // byte codes 0..3 low halves, 4..7 high halves of regs 0..3
            if (wr.byte_a_en && i < 4 && wr.byte_a_code[1:0] == 2'(i)) begin
               if (wr.byte_a_code[2]) regs_in[i][15:8] = wr.byte_a_data;
               else                   regs_in[i][7:0]  = wr.byte_a_data;
            end
            if (wr.byte_b_en && i < 4 && wr.byte_b_code[1:0] == 2'(i)) begin
               if (wr.byte_b_code[2]) regs_in[i][15:8] = wr.byte_b_data;
               else                   regs_in[i][7:0]  = wr.byte_b_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reset) regs_ff[i] <= '0;
         else       regs_ff[i] <= regs_in[i];
      end
   end

   assign rd_a_data = regs_ff[rd_a_idx];
   assign rd_b_data = regs_ff[rd_b_idx];
   assign ax_data   = regs_ff[0];

endmodule

@@ src/x86s_exec.sv @@
// ----------------------------------------------------------------------------
// x86s_exec
// decode and alu for one instruction, pure combinational
// ----------------------------------------------------------------------------
module x86s_exec import x86s_pkg::*; (
   input  logic [7:0]           opcode,
   input  logic [7:0]           second_byte,
   input  logic [7:0]           third_byte,
   input  logic [15:0]          ip,
   input  logic [FLAG_W-1:0]    flags,
   input  logic [REG_W-1:0]     rd_a_data,
   input  logic [REG_W-1:0]     rd_b_data,
   input  logic [REG_W-1:0]     ax_data,
   output logic [REG_IDX_W-1:0] rd_a_idx,
   output logic [REG_IDX_W-1:0] rd_b_idx,
   output rf_wr_type            wr,
   output exec_res_type         res
);

   logic [1:0]           modf;
   logic [2:0]           rg;
   logic [2:0]           rm;
   logic [7:0]           a8;
   logic [7:0]           b8;
   logic [2:0]           xor_dst;
   logic [15:0]          acc;
   logic [15:0]          imm;
   logic [16:0]          diff;
   logic [15:0]          cres;
   logic                 msb_bit;
   logic                 sign_res;
   logic                 sign_acc;
   logic                 sign_imm;
   logic [FLAG_W-1:0]    cmp_flags;
   logic [1:0]           len;
   logic                 jump;
   logic [15:0]          offset;

   assign modf = second_byte[7:6];
   assign rg   = second_byte[5:3];
   assign rm   = second_byte[2:0];

   // byte forms address the register holding the byte (code mod 4)
   assign rd_a_idx = opcode[0] ? rg : {1'b0, rg[1:0]};
   assign rd_b_idx = opcode[0] ? rm : {1'b0, rm[1:0]};
   assign a8 = rg[2] ? rd_a_data[15:8] : rd_a_data[7:0];
   assign b8 = rm[2] ? rd_b_data[15:8] : rd_b_data[7:0];
   assign xor_dst = opcode[1] ? rg : rm;

   // compare: acc minus imm at byte or word width
   assign acc  = opcode[0] ? ax_data : {8'h00, ax_data[7:0]};
   assign imm  = opcode[0] ? {third_byte, second_byte} : {8'h00, second_byte};
   assign diff = {1'b0, acc} - {1'b0, imm};
   assign cres = opcode[0] ? diff[15:0] : {8'h00, diff[7:0]};
   assign sign_res = opcode[0] ? cres[15] : cres[7];
   assign sign_acc = opcode[0] ? acc[15]  : acc[7];
   assign sign_imm = opcode[0] ? imm[15]  : imm[7];
   assign msb_bit  = (sign_acc ^ sign_imm) & (sign_acc ^ sign_res);

   always_comb begin
      cmp_flags          = '0;
      cmp_flags[FLAG_CF] = diff[16];
      cmp_flags[FLAG_PF] = ~^cres[7:0];
      cmp_flags[FLAG_AF] = imm[3:0] > acc[3:0];
      cmp_flags[FLAG_ZF] = (cres == 16'h0000);
      cmp_flags[FLAG_SF] = sign_res;
      cmp_flags[FLAG_OF] = msb_bit;
   end

   assign offset = {{8{second_byte[7]}}, second_byte};

   always_comb begin
      wr             = '0;
      res.status     = ST_DONE;
      res.flags_we   = 1'b0;
      res.flags      = flags;
      res.int_vector = 8'h00;
      len            = LEN_TWO;
      jump           = 1'b0;

      unique case (opcode) inside
         OP_INT: begin
            res.status     = ST_INT;
            res.int_vector = second_byte;
         end
         OP_MOV_IMM: begin
            if (opcode[3]) begin
               wr.word_en   = 1'b1;
               wr.word_idx  = opcode[2:0];
               wr.word_data = {third_byte, second_byte};
               len          = LEN_THREE;
            end else begin
               wr.byte_a_en   = 1'b1;
               wr.byte_a_code = opcode[2:0];
               wr.byte_a_data = second_byte;
            end
         end
         OP_XCHG: begin
            if (!opcode[0] && modf == MOD_REG) begin
               wr.byte_a_en   = 1'b1;
               wr.byte_a_code = rm;
               wr.byte_a_data = a8;
               wr.byte_b_en   = 1'b1;
               wr.byte_b_code = rg;
               wr.byte_b_data = b8;
            end else begin
               res.status = ST_UNSUPPORTED;
            end
         end
         OP_CMP_ACC: begin
            res.flags_we = 1'b1;
            res.flags    = cmp_flags;
            if (opcode[0]) len = LEN_THREE;
         end
         OP_JAE: begin
            jump = ~flags[FLAG_CF];
         end
         OP_XOR: begin
            if (modf != MOD_REG) begin
               res.status = ST_UNSUPPORTED;
            end else if (opcode[0]) begin
               wr.word_en   = 1'b1;
               wr.word_idx  = xor_dst;
               wr.word_data = rd_a_data ^ rd_b_data;
            end else begin
               wr.byte_a_en   = 1'b1;
               wr.byte_a_code = xor_dst;
               wr.byte_a_data = a8 ^ b8;
            end
         end
         default: begin
            res.status = ST_UNKNOWN;
            len        = LEN_ONE;
         end
      endcase

      res.next_ip = ip + {14'h0000, len} + (jump ? offset : 16'h0000);
   end

endmodule

@@ src/x86_16_subset_execute.sv @@
// ----------------------------------------------------------------------------
// x86_16_subset_execute
// flow: request held in input stage, then its result in the response register
// throughput: one instruction per cycle while rsp.ready holds, set by the single
//   execute stage that reads/writes register file, flags and ip in the same cycle
// reset: synchronous; registers, flags cleared, ip loads the start ip reset
//   value (zero); a csr write loads ip at once
// ----------------------------------------------------------------------------
module x86_16_subset_execute import x86s_pkg::*; (
   input logic       clock,
   input logic       reset,
   x86s_req_if.sink   req,
   x86s_rsp_if.source rsp,
   x86s_csr_if.sink   csr
);

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_opcode_ff;
   logic [7:0] s1_second_ff;
   logic [7:0] s1_third_ff;

   // architectural state
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [15:0]       ip_ff, ip_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [15:0]       rsp_ip_ff;
   logic [FLAG_W-1:0] rsp_flags_ff;
   logic [7:0]        rsp_vec_ff;

   logic                 req_take;
   logic                 fire;
   logic [REG_IDX_W-1:0] rd_a_idx, rd_b_idx;
   logic [REG_W-1:0]     rd_a_data, rd_b_data, ax_data;
   rf_wr_type            rf_wr;
   exec_res_type         ex_res;

   // the execute stage retires when the response slot is free or draining
   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || fire;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // register file, written only when the instruction retires
   x86s_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (fire),
      .wr        (rf_wr),
      .rd_a_idx  (rd_a_idx),
      .rd_b_idx  (rd_b_idx),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .ax_data   (ax_data)
   );

   // decode and alu
   x86s_exec u_exec (
      .opcode      (s1_opcode_ff),
      .second_byte (s1_second_ff),
      .third_byte  (s1_third_ff),
      .ip          (ip_ff),
      .flags       (flags_ff),
      .rd_a_data   (rd_a_data),
      .rd_b_data   (rd_b_data),
      .ax_data     (ax_data),
      .rd_a_idx    (rd_a_idx),
      .rd_b_idx    (rd_b_idx),
      .wr          (rf_wr),
      .res         (ex_res)
   );

   always_comb begin
      // input stage occupancy
      if (req_take)  s1_valid_in = 1'b1;
      else if (fire) s1_valid_in = 1'b0;
      else           s1_valid_in = s1_valid_ff;

      // response slot occupancy
      if (fire)           rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;

      // flags change only on compare
      flags_in = (fire && ex_res.flags_we) ? ex_res.flags : flags_ff;

      // csr write reloads ip; user sends only while idle, not enforced
      if (csr.valid)  ip_in = csr.data;
      else if (fire)  ip_in = ex_res.next_ip;
      else            ip_in = ip_ff;
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         ip_ff        <= 16'h0000;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         ip_ff        <= ip_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req.opcode;
         s1_second_ff <= req.second_byte;
         s1_third_ff  <= req.third_byte;
      end
   end

   // response payload capture
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= ex_res.status;
         rsp_ip_ff     <= ex_res.next_ip;
         rsp_flags_ff  <= flags_in;
         rsp_vec_ff    <= ex_res.int_vector;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.next_ip    = rsp_ip_ff;
   assign rsp.flag_bits  = rsp_flags_ff;
   assign rsp.int_vector = rsp_vec_ff;

endmodule
